/* src/csr_sparse_matrix_vector_multiply_defines.svh */
// assertion macros shared by the csr sparse matrix-vector multiply rtl
// no dependencies; included by modules that carry assertions
`ifndef CSR_SPARSE_MATRIX_VECTOR_MULTIPLY_DEFINES_SVH
`define CSR_SPARSE_MATRIX_VECTOR_MULTIPLY_DEFINES_SVH

// checked on every clock edge outside reset
`define CSMV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every clock edge, reset included
`define CSMV_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* src/csmv_pkg.sv */
// types and constants for the csr sparse matrix-vector multiply block
// no dependencies
package csmv_pkg;

  localparam int unsigned VectorDepth = 4096;
  localparam int unsigned VecAddrW    = $clog2(VectorDepth);
  localparam int unsigned ColW        = 12;
  localparam int unsigned ValW        = 32;
  localparam int unsigned SumW        = 64;
  localparam int unsigned RowNumW     = 20;
  localparam int unsigned RowCntW     = 20;
  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned QueuePtrW   = $clog2(QueueDepth);
  localparam int unsigned QueueCntW   = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    ActLoad    = 2'd0,
    ActNonzero = 2'd1,
    ActEmpty   = 2'd2,
    ActUnused  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    OpClear = 2'd0,
    OpMac   = 2'd1,
    OpEmpty = 2'd2
  } op_e;

  typedef struct packed {
    op_e                    op;
    logic                   last;
    logic signed [ValW-1:0] vec;
    logic signed [ValW-1:0] mat;
  } work_t;

endpackage

/* src/csmv_if.sv */
// valid/ready channel interfaces for the input and result words
// depends on csmv_pkg
interface csmv_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          action;
  logic [csmv_pkg::ColW-1:0]           col_index;
  logic signed [csmv_pkg::ValW-1:0]    value;
  logic                                row_end;

  modport source (output valid, action, col_index, value, row_end, input ready);
  modport sink (input valid, action, col_index, value, row_end, output ready);
endinterface

interface csmv_out_if;
  logic                                valid;
  logic                                ready;
  logic [csmv_pkg::RowNumW-1:0]        row_number;
  logic signed [csmv_pkg::SumW-1:0]    row_sum;
  logic                                saturated;

  modport source (output valid, row_number, row_sum, saturated, input ready);
  modport sink (input valid, row_number, row_sum, saturated, output ready);
endinterface

/* src/csr_sparse_matrix_vector_multiply.sv */
// Sparse matrix times dense vector in compressed-row order, Q16.16 inputs and
// saturating Q32.32 row sums. Takes one input word per clock cycle when the
// result side keeps up; a nonzero is limited by the single read port of the
// 4096 x 32 vector store and one 32 x 32 multiply-accumulate per cycle. A row
// result passes from the store read and its register through the queue, the
// product register and the result register. A result waiting at the output
// stalls input only once the four-word queue between the front and back ends
// and the registers around it have filled.
// The vector store has no reset; entries read before they are written are
// undefined.
// depends on csmv_pkg, csmv_if, csmv_front, csmv_fifo and csmv_back
module csr_sparse_matrix_vector_multiply (
  input  logic        clk_i,
  input  logic        rst_ni,
  csmv_in_if.sink     in_i,
  csmv_out_if.source  out_o
);

  csmv_pkg::work_t front_item;
  logic            front_valid;
  logic            front_ready;
  csmv_pkg::work_t back_item;
  logic            back_valid;
  logic            back_ready;

  csmv_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_o       (front_item),
    .item_valid_o (front_valid),
    .item_ready_i (front_ready)
  );

  csmv_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_item_i  (front_item),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_item_o   (back_item),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready)
  );

  csmv_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (back_item),
    .item_valid_i (back_valid),
    .item_ready_o (back_ready),
    .out_o        (out_o)
  );

endmodule

/* src/csmv_front.sv */
// front end: accepts input words, decodes them and owns the vector store
// depends on csmv_pkg and csmv_in_if
module csmv_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  csmv_in_if.sink           in_i,
  output csmv_pkg::work_t   item_o,
  output logic              item_valid_o,
  input  logic              item_ready_i
);

  logic [csmv_pkg::ValW-1:0] vmem [csmv_pkg::VectorDepth];

  logic [csmv_pkg::VecAddrW-1:0] addr;
  logic                          accept;
  logic                          in_range;
  logic                          keep;
  csmv_pkg::op_e                 op;
  csmv_pkg::action_e             action;

  logic                          valid_q;
  csmv_pkg::op_e                 op_q;
  logic                          last_q;
  logic                          in_range_q;
  logic [csmv_pkg::ValW-1:0]     mat_q;
  logic [csmv_pkg::ValW-1:0]     rdata_q;

  assign action   = csmv_pkg::action_e'(in_i.action);
  assign addr     = csmv_pkg::VecAddrW'(in_i.col_index);
  assign in_range = 32'(in_i.col_index) < csmv_pkg::VectorDepth;
  assign in_i.ready = !valid_q || item_ready_i;
  assign accept   = in_i.valid && in_i.ready;

  always_comb begin
    keep = 1'b1;
    op   = csmv_pkg::OpClear;
    unique case (action)
      csmv_pkg::ActLoad:    op = csmv_pkg::OpClear;
      csmv_pkg::ActNonzero: op = csmv_pkg::OpMac;
      csmv_pkg::ActEmpty:   op = csmv_pkg::OpEmpty;
      csmv_pkg::ActUnused:  keep = 1'b0;
      default:              keep = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept && action == csmv_pkg::ActLoad && in_range) begin
      vmem[addr] <= in_i.value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rdata_q    <= vmem[addr];
      op_q       <= op;
      last_q     <= in_i.row_end;
      in_range_q <= in_range;
      mat_q      <= in_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= accept && keep;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o.op    = op_q;
  assign item_o.last  = last_q;
  assign item_o.vec   = in_range_q ? rdata_q : '0;
  assign item_o.mat   = mat_q;

endmodule

/* src/csmv_fifo.sv */
// short queue of decoded words between front and back end
// depends on csmv_pkg and the assertion macro header
`include "csr_sparse_matrix_vector_multiply_defines.svh"

module csmv_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  csmv_pkg::work_t   push_item_i,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  output csmv_pkg::work_t   pop_item_o,
  output logic              pop_valid_o,
  input  logic              pop_ready_i
);

  csmv_pkg::work_t                mem_q [csmv_pkg::QueueDepth];
  logic [csmv_pkg::QueuePtrW-1:0] wptr_q, wptr_d;
  logic [csmv_pkg::QueuePtrW-1:0] rptr_q, rptr_d;
  logic [csmv_pkg::QueueCntW-1:0] count_q, count_d;
  logic                           push;
  logic                           pop;

  assign push_ready_o = count_q != csmv_pkg::QueueCntW'(csmv_pkg::QueueDepth);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rptr_q];

  always_comb begin
    wptr_d  = push ? wptr_q + 1'b1 : wptr_q;
    rptr_d  = pop ? rptr_q + 1'b1 : rptr_q;
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  `CSMV_ASSERT(count_bound_a, count_q <= csmv_pkg::QueueCntW'(csmv_pkg::QueueDepth), "queue overfilled")
  `CSMV_ASSERT(count_track_a, push && !pop |=> count_q == $past(count_q) + 1'b1, "queue count lost a word")
  `CSMV_ASSERT_ALWAYS(count_rst_a, $rose(rst_ni) |-> count_q == '0, "queue not empty out of reset")

endmodule

/* src/csmv_back.sv */
// back end: multiply, saturating row accumulation and result register
// depends on csmv_pkg, csmv_out_if and the assertion macro header
`include "csr_sparse_matrix_vector_multiply_defines.svh"

module csmv_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  csmv_pkg::work_t   item_i,
  input  logic              item_valid_i,
  output logic              item_ready_o,
  csmv_out_if.source        out_o
);

  logic                             b1_valid_q;
  csmv_pkg::op_e                    b1_op_q;
  logic                             b1_last_q;
  logic signed [csmv_pkg::SumW-1:0] prod_q;
  logic signed [csmv_pkg::SumW-1:0] prod_d;

  logic signed [csmv_pkg::SumW-1:0] acc_q, acc_d;
  logic                             clip_q, clip_d;
  logic [csmv_pkg::RowCntW-1:0]     row_cnt_q, row_cnt_d;

  logic                             out_valid_q;
  logic [csmv_pkg::RowNumW-1:0]     out_row_q;
  logic signed [csmv_pkg::SumW-1:0] out_sum_q;
  logic                             out_sat_q;

  logic                             produces;
  logic                             exec;
  logic [csmv_pkg::SumW:0]          wide_sum;
  logic                             ovf;
  logic signed [csmv_pkg::SumW-1:0] sat_sum;
  logic signed [csmv_pkg::SumW-1:0] res_sum;
  logic                             res_sat;

  assign prod_d = $signed(item_i.vec) * $signed(item_i.mat);

  assign produces = (b1_op_q == csmv_pkg::OpEmpty) ||
                    (b1_op_q == csmv_pkg::OpMac && b1_last_q);
  assign exec = b1_valid_q && (!produces || !out_valid_q || out_o.ready);
  assign item_ready_o = !b1_valid_q || exec;

  // saturating add of the product into the row sum
  assign wide_sum = {acc_q[csmv_pkg::SumW-1], acc_q} + {prod_q[csmv_pkg::SumW-1], prod_q};
  assign ovf      = wide_sum[csmv_pkg::SumW] != wide_sum[csmv_pkg::SumW-1];
  always_comb begin
    sat_sum = wide_sum[csmv_pkg::SumW-1:0];
    if (ovf) begin
      sat_sum = wide_sum[csmv_pkg::SumW] ? {1'b1, {(csmv_pkg::SumW-1){1'b0}}}
                                         : {1'b0, {(csmv_pkg::SumW-1){1'b1}}};
    end
  end

  always_comb begin
    acc_d     = acc_q;
    clip_d    = clip_q;
    row_cnt_d = row_cnt_q;
    res_sum   = '0;
    res_sat   = 1'b0;
    unique case (b1_op_q)
      csmv_pkg::OpClear: begin
        acc_d     = '0;
        clip_d    = 1'b0;
        row_cnt_d = '0;
      end
      csmv_pkg::OpMac: begin
        res_sum = sat_sum;
        res_sat = clip_q || ovf;
        if (b1_last_q) begin
          acc_d     = '0;
          clip_d    = 1'b0;
          row_cnt_d = row_cnt_q + 1'b1;
        end else begin
          acc_d  = sat_sum;
          clip_d = clip_q || ovf;
        end
      end
      csmv_pkg::OpEmpty: begin
        acc_d     = '0;
        clip_d    = 1'b0;
        row_cnt_d = row_cnt_q + 1'b1;
      end
      default: begin
        acc_d = acc_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (item_ready_o && item_valid_i) begin
      b1_op_q   <= item_i.op;
      b1_last_q <= item_i.last;
      prod_q    <= prod_d;
    end
    if (exec && produces) begin
      out_row_q <= csmv_pkg::RowNumW'(row_cnt_q);
      out_sum_q <= res_sum;
      out_sat_q <= res_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q  <= 1'b0;
      acc_q       <= '0;
      clip_q      <= 1'b0;
      row_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (item_ready_o) begin
        b1_valid_q <= item_valid_i;
      end
      if (exec) begin
        acc_q     <= acc_d;
        clip_q    <= clip_d;
        row_cnt_q <= row_cnt_d;
      end
      if (exec && produces) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.row_number = out_row_q;
  assign out_o.row_sum    = out_sum_q;
  assign out_o.saturated  = out_sat_q;

  `CSMV_ASSERT(clear_cnt_a, exec && b1_op_q == csmv_pkg::OpClear |=> row_cnt_q == '0, "row count not cleared by load")
  `CSMV_ASSERT(close_acc_a, exec && produces |=> acc_q == '0 && !clip_q, "row sum not cleared on close")
  `CSMV_ASSERT(no_drop_a, out_valid_q && !out_o.ready |=> out_valid_q && $stable(out_sum_q), "stalled result changed")

endmodule
